/* rtl/fpcd_pkg.sv */
// Package for the FIFO page cache directory.
// Holds sizes, command and status codes, the slot word and the control structs.
// No dependencies.
`default_nettype none

package fpcd_pkg;

  localparam int MAX_SLOTS   = 416;
  localparam int ROM_PAGES   = 128;
  localparam int ROM_VOLUMES = 3;
  localparam int NOR_PAGES   = 32;
  localparam int ROM_ENTRIES = ROM_VOLUMES * ROM_PAGES;

  localparam int SLOT_W = 9;
  localparam int PAGE_W = 7;
  localparam int VOL_W  = 2;
  localparam int NOR_W  = 5;
  localparam int CMD_W  = 3;
  localparam int ST_W   = 2;

  localparam logic [SLOT_W-1:0] NOT_CACHED  = 9'h1ff;
  localparam logic [SLOT_W-1:0] MAX_SLOTS_V = SLOT_W'(MAX_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(MAX_SLOTS - 1);
  localparam logic [1:0]        KIND_NOR    = 2'b11;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_ROM   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_NOR   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MARK_DIRTY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WIPE_NOR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLUSH      = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [ST_W-1:0] ST_STALE  = 2'd2;
  localparam logic [ST_W-1:0] ST_NO_MAP = 2'd3;

  // One slot's directory word
  typedef struct packed {
    logic              used;
    logic              dirty;
    logic [1:0]        kind;
    logic [PAGE_W-1:0] page;
  } slot_t;

  // One result beat
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              fill_needed;
    logic              writeback;
    logic [NOR_W-1:0]  writeback_page;
    logic [SLOT_W-1:0] writeback_slot;
    logic              last;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;
    logic idle;
    logic dec;
    logic evict;
    logic commit;
    logic dirty_wr;
    logic walk_rd;
    logic walk_chk;
    logic finish;
    logic emit;
    logic next_page;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic acc;
    logic dec_done;
    logic dec_miss;
    logic dec_mark;
    logic walk_valid;
    logic walk_last;
    logic chk_stall;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/fpcd_if.sv */
// Valid/ready channel interfaces for the page cache directory.
// Command channel and result channel; no dependencies.
`default_nettype none

interface fpcd_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [1:0] volume;
  logic [6:0] page;

  modport source (output valid, cmd, volume, page, input ready);
  modport sink   (input valid, cmd, volume, page, output ready);
endinterface

interface fpcd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       hit;
  logic [8:0] slot;
  logic       fill_needed;
  logic       writeback;
  logic [4:0] writeback_page;
  logic [8:0] writeback_slot;
  logic       last;

  modport source (output valid, status, hit, slot, fill_needed, writeback,
                  writeback_page, writeback_slot, last, input ready);
  modport sink   (input valid, status, hit, slot, fill_needed, writeback,
                  writeback_page, writeback_slot, last, output ready);
endinterface

`default_nettype wire

/* rtl/fpcd_dp.sv */
// Datapath of the page cache directory: maps, slot memory, pointers, result regs.
// Depends on fpcd_pkg and fpcd_if; driven by fpcd_ctrl commands.
`default_nettype none

module fpcd_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fpcd_pkg::ctl_t                ctl,
  output fpcd_pkg::sts_t                sts,
  fpcd_in_if.sink                       in_chan,
  fpcd_out_if.source                    out_chan,
  input  logic                          cfg_we,
  input  logic [fpcd_pkg::SLOT_W-1:0]   cfg_wdata
);
  import fpcd_pkg::*;

  function automatic res_t mk_res(logic [ST_W-1:0] st, logic h, logic [SLOT_W-1:0] s,
                                  logic f, logic wb, logic [NOR_W-1:0] wbp,
                                  logic [SLOT_W-1:0] wbs, logic l);
    res_t r;
    r.status = st; r.hit = h; r.slot = s; r.fill_needed = f;
    r.writeback = wb; r.writeback_page = wbp; r.writeback_slot = wbs; r.last = l;
    return r;
  endfunction

  // Storage
  logic [SLOT_W-1:0] rom_map_mem [ROM_ENTRIES];
  slot_t             slot_mem    [MAX_SLOTS];
  logic [SLOT_W-1:0] nor_map_r   [NOR_PAGES];

  logic [SLOT_W-1:0] cfg_r, clr_cnt_r, rom_rd_r, slot_addr_r, vp_r;
  slot_t             slot_rd_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [VOL_W-1:0]  vol_r;
  logic [PAGE_W-1:0] page_r;
  logic [NOR_W-1:0]  mnp_r, wbp_r, p_r;
  logic              mnv_r, wb_r, pend_v_r, out_v_r;
  res_t              res_r, pend_r, out_r;

  logic [SLOT_W-1:0] eff_n, cur, victim, mark_s, walk_s, rd_addr;
  logic [SLOT_W:0]   vnext;
  logic              is_rom, is_nor, is_load, is_mark, is_wipe, is_flush, bad;
  logic              cached, stale, mark_ok, rd_en, nor_ok, fh, push_walk, push_emit;
  logic              rom_we, slot_we;
  logic [SLOT_W-1:0] rom_wa, rom_wd;
  logic [SLOT_W-1:0] slot_wa;
  slot_t             slot_wd;

  // Effective slot count
  always_comb begin
    priority if (cfg_r == '0) eff_n = SLOT_W'(1);
    else if (cfg_r > MAX_SLOTS_V) eff_n = MAX_SLOTS_V;
    else eff_n = cfg_r;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= MAX_SLOTS_V;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // Input handshake and latch
  assign in_chan.ready = ctl.idle;
  assign sts.acc       = ctl.idle & in_chan.valid;

  always_ff @(posedge clk) begin
    if (sts.acc) begin
      cmd_r  <= in_chan.cmd;
      vol_r  <= in_chan.volume;
      page_r <= in_chan.page;
    end
  end

  // ROM map read at accept
  always_ff @(posedge clk) begin
    if (sts.acc && in_chan.volume < VOL_W'(ROM_VOLUMES)) begin
      rom_rd_r <= rom_map_mem[{in_chan.volume, in_chan.page}];
    end
  end

  // Command decode
  always_comb begin
    is_rom   = (cmd_r == CMD_LOAD_ROM);
    is_nor   = (cmd_r == CMD_LOAD_NOR);
    is_mark  = (cmd_r == CMD_MARK_DIRTY);
    is_wipe  = (cmd_r == CMD_WIPE_NOR);
    is_flush = (cmd_r == CMD_FLUSH);
    is_load  = is_rom | is_nor;
    bad      = (is_rom && vol_r >= VOL_W'(ROM_VOLUMES)) ||
               (is_nor && page_r >= PAGE_W'(NOR_PAGES)) ||
               (cmd_r > CMD_FLUSH);
    cur      = is_rom ? rom_rd_r : nor_map_r[page_r[NOR_W-1:0]];
    cached   = (cur != NOT_CACHED);
    stale    = cached && (cur >= eff_n);
    mark_s   = nor_map_r[mnp_r];
    mark_ok  = mnv_r && (mark_s != NOT_CACHED) && (mark_s < eff_n);
    victim   = (vp_r >= eff_n) ? '0 : vp_r;
    vnext    = {1'b0, slot_addr_r} + (SLOT_W+1)'(1);
    walk_s   = nor_map_r[p_r];
  end

  assign sts.dec_done   = bad || (is_load && cached) || (is_mark && !mark_ok);
  assign sts.dec_miss   = is_load && !bad && !cached;
  assign sts.dec_mark   = is_mark && mark_ok;
  assign sts.walk_valid = (walk_s != NOT_CACHED) && (walk_s < MAX_SLOTS_V);
  assign sts.walk_last  = (p_r == NOR_W'(NOR_PAGES - 1));
  assign sts.clr_done   = (clr_cnt_r == LAST_SLOT);

  // Walk check on the slot word just read
  assign nor_ok        = slot_rd_r.used && (slot_rd_r.kind == KIND_NOR);
  assign fh            = is_flush && nor_ok && slot_rd_r.dirty;
  assign sts.out_free  = !out_v_r || out_chan.ready;
  assign sts.chk_stall = fh && pend_v_r && !sts.out_free;
  assign push_walk     = ctl.walk_chk && fh && !sts.chk_stall && pend_v_r;
  assign push_emit     = ctl.emit && sts.out_free;

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (ctl.clr && !sts.clr_done) begin
      clr_cnt_r <= clr_cnt_r + SLOT_W'(1);
    end
  end

  // ROM map write port
  always_comb begin
    rom_we = 1'b0;
    rom_wa = clr_cnt_r;
    rom_wd = NOT_CACHED;
    priority if (ctl.clr) begin
      rom_we = (clr_cnt_r < SLOT_W'(ROM_ENTRIES));
    end else if (ctl.evict) begin
      rom_we = slot_rd_r.used && (slot_rd_r.kind != KIND_NOR);
      rom_wa = {slot_rd_r.kind, slot_rd_r.page};
    end else if (ctl.commit) begin
      rom_we = is_rom;
      rom_wa = {vol_r, page_r};
      rom_wd = slot_addr_r;
    end else begin
      rom_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom_map_mem[rom_wa] <= rom_wd;
    end
  end

  // NOR map in flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NOR_PAGES; i++) nor_map_r[i] <= NOT_CACHED;
    end else begin
      if (ctl.evict && slot_rd_r.used && slot_rd_r.kind == KIND_NOR &&
          slot_rd_r.page < PAGE_W'(NOR_PAGES)) begin
        nor_map_r[slot_rd_r.page[NOR_W-1:0]] <= NOT_CACHED;
      end
      if (ctl.commit && is_nor) begin
        nor_map_r[page_r[NOR_W-1:0]] <= slot_addr_r;
      end
    end
  end

  // Slot memory read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = victim;
    priority if (ctl.dec && sts.dec_miss) begin
      rd_en = 1'b1;
    end else if (ctl.dec && sts.dec_mark) begin
      rd_en   = 1'b1;
      rd_addr = mark_s;
    end else if (ctl.walk_rd && sts.walk_valid) begin
      rd_en   = 1'b1;
      rd_addr = walk_s;
    end else begin
      rd_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      slot_rd_r   <= slot_mem[rd_addr];
      slot_addr_r <= rd_addr;
    end
  end

  // Slot memory write port
  always_comb begin
    slot_we = 1'b0;
    slot_wa = slot_addr_r;
    slot_wd = slot_rd_r;
    priority if (ctl.clr) begin
      slot_we = 1'b1;
      slot_wa = clr_cnt_r;
      slot_wd = '0;
    end else if (ctl.commit) begin
      slot_we       = 1'b1;
      slot_wd.used  = 1'b1;
      slot_wd.dirty = 1'b0;
      slot_wd.kind  = is_rom ? vol_r : KIND_NOR;
      slot_wd.page  = page_r;
    end else if (ctl.dirty_wr) begin
      slot_we       = 1'b1;
      slot_wd.dirty = 1'b1;
    end else if (ctl.walk_chk) begin
      slot_we       = (is_wipe && nor_ok) || (fh && !sts.chk_stall);
      slot_wd.dirty = 1'b0;
    end else begin
      slot_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
  end

  // Victim pointer, mapped NOR page, eviction writeback
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r  <= '0;
      mnp_r <= '0;
      mnv_r <= 1'b0;
    end else begin
      if (ctl.commit) begin
        vp_r <= (vnext >= {1'b0, eff_n}) ? '0 : vnext[SLOT_W-1:0];
      end
      if ((ctl.commit && is_nor) ||
          (ctl.dec && is_nor && !bad && cached && !stale)) begin
        mnp_r <= page_r[NOR_W-1:0];
        mnv_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.evict) begin
      wb_r  <= slot_rd_r.used && (slot_rd_r.kind == KIND_NOR) && slot_rd_r.dirty;
      wbp_r <= slot_rd_r.page[NOR_W-1:0];
    end
  end

  // Walk page counter and pending flush beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r      <= '0;
      pend_v_r <= 1'b0;
    end else begin
      if (ctl.dec) begin
        p_r      <= '0;
        pend_v_r <= 1'b0;
      end else if (ctl.next_page) begin
        p_r <= p_r + NOR_W'(1);
      end
      if (ctl.walk_chk && fh && !sts.chk_stall) begin
        pend_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.walk_chk && fh && !sts.chk_stall) begin
      pend_r <= mk_res(ST_DONE, 1'b0, '0, 1'b0, 1'b1, p_r, slot_addr_r, 1'b0);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    priority if (ctl.dec && sts.dec_done) begin
      priority if (bad)
        res_r <= mk_res(ST_RANGE, 1'b0, '0, 1'b0, 1'b0, '0, '0, 1'b1);
      else if (is_mark && (!mnv_r || mark_s == NOT_CACHED))
        res_r <= mk_res(ST_NO_MAP, 1'b0, '0, 1'b0, 1'b0, '0, '0, 1'b1);
      else if (is_mark || stale)
        res_r <= mk_res(ST_STALE, 1'b0, '0, 1'b0, 1'b0, '0, '0, 1'b1);
      else
        res_r <= mk_res(ST_DONE, 1'b1, cur, 1'b0, 1'b0, '0, '0, 1'b1);
    end else if (ctl.commit) begin
      res_r <= mk_res(ST_DONE, 1'b0, slot_addr_r, 1'b1, wb_r,
                      wb_r ? wbp_r : '0, wb_r ? slot_addr_r : '0, 1'b1);
    end else if (ctl.dirty_wr) begin
      res_r <= mk_res(ST_DONE, 1'b0, slot_addr_r, 1'b0, 1'b0, '0, '0, 1'b1);
    end else if (ctl.finish) begin
      if (is_flush && pend_v_r) begin
        // held flush beat closes the item
        res_r <= mk_res(pend_r.status, pend_r.hit, pend_r.slot, pend_r.fill_needed,
                        pend_r.writeback, pend_r.writeback_page,
                        pend_r.writeback_slot, 1'b1);
      end else begin
        res_r <= mk_res(ST_DONE, 1'b0, '0, 1'b0, 1'b0, '0, '0, 1'b1);
      end
    end else begin
      res_r <= res_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push_emit || push_walk) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_walk) begin
      out_r <= pend_r;
    end else if (push_emit) begin
      out_r <= res_r;
    end
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.status         = out_r.status;
  assign out_chan.hit            = out_r.hit;
  assign out_chan.slot           = out_r.slot;
  assign out_chan.fill_needed    = out_r.fill_needed;
  assign out_chan.writeback      = out_r.writeback;
  assign out_chan.writeback_page = out_r.writeback_page;
  assign out_chan.writeback_slot = out_r.writeback_slot;
  assign out_chan.last           = out_r.last;

  // Checks
  a_vp_range: assert property (@(posedge clk) disable iff (!rst_n)
    vp_r < MAX_SLOTS_V) else $error("victim pointer beyond slot memory");

  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> (slot_addr_r < eff_n)) else $error("claimed slot beyond count");

  a_mark_used: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.dirty_wr |-> slot_rd_r.used) else $error("dirty mark on unused slot");

endmodule

`default_nettype wire

/* rtl/fpcd_ctrl.sv */
// Controller state machine of the page cache directory.
// Depends on fpcd_pkg; issues ctl_t commands to fpcd_dp and reads sts_t.
`default_nettype none

module fpcd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  fpcd_pkg::sts_t sts,
  output fpcd_pkg::ctl_t ctl
);
  import fpcd_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_DEC   = 10'b0000000100,
    S_EVT   = 10'b0000001000,
    S_CMT   = 10'b0000010000,
    S_DWR   = 10'b0000100000,
    S_WALK  = 10'b0001000000,
    S_WCHK  = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE:  if (sts.acc) state_nxt = S_DEC;
      S_DEC: begin
        priority if (sts.dec_done) state_nxt = S_EMIT;
        else if (sts.dec_miss) state_nxt = S_EVT;
        else if (sts.dec_mark) state_nxt = S_DWR;
        else state_nxt = S_WALK;
      end
      S_EVT:   state_nxt = S_CMT;
      S_CMT:   state_nxt = S_EMIT;
      S_DWR:   state_nxt = S_EMIT;
      S_WALK: begin
        priority if (sts.walk_valid) state_nxt = S_WCHK;
        else if (sts.walk_last) state_nxt = S_FIN;
        else state_nxt = S_WALK;
      end
      S_WCHK: begin
        priority if (sts.chk_stall) state_nxt = S_WCHK;
        else if (sts.walk_last) state_nxt = S_FIN;
        else state_nxt = S_WALK;
      end
      S_FIN:   state_nxt = S_EMIT;
      S_EMIT:  if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands
  always_comb begin
    ctl.clr       = (state_r == S_CLEAR);
    ctl.idle      = (state_r == S_IDLE);
    ctl.dec       = (state_r == S_DEC);
    ctl.evict     = (state_r == S_EVT);
    ctl.commit    = (state_r == S_CMT);
    ctl.dirty_wr  = (state_r == S_DWR);
    ctl.walk_rd   = (state_r == S_WALK);
    ctl.walk_chk  = (state_r == S_WCHK);
    ctl.finish    = (state_r == S_FIN);
    ctl.emit      = (state_r == S_EMIT);
    ctl.next_page = ((state_r == S_WALK) && !sts.walk_valid && !sts.walk_last) ||
                    ((state_r == S_WCHK) && !sts.chk_stall && !sts.walk_last);
  end

  // Checks
  a_evict_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.evict |=> ctl.commit) else $error("eviction not followed by commit");

  a_dec_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.idle && sts.acc) |=> ctl.dec) else $error("accepted beat not decoded");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.idle |=> !ctl.clr) else $error("clear pass re-entered");

endmodule

`default_nettype wire

/* rtl/fifo_page_cache_directory.sv */
// Top level of the FIFO page cache directory.
// Depends on fpcd_pkg, fpcd_if, fpcd_ctrl and fpcd_dp.
//
//  channel   | dir | handshake            | payload
//  in_chan   | in  | valid/ready          | cmd, volume, page
//  out_chan  | out | valid/ready          | status, hit, slot, fill_needed,
//            |     |                      | writeback, writeback_page/slot, last
//  cfg       | in  | cfg_we, no wait      | cfg_wdata = slots_in_use
//
// After reset a clearing pass sweeps the ROM map and slot memory;
// in_chan.ready stays low until it ends. Reset is synchronous, active low.
// A hit or error passes decode and emit, a miss decode, evict, commit and
// emit, a mark-dirty decode, dirty write and emit. Wipe and flush walk the
// 32 NOR pages, checking the slot word of each mapped page. Output stalls hold
// the controller only where a result has to be placed in the output register.
`default_nettype none

module fifo_page_cache_directory (
  input  logic                        clk,
  input  logic                        rst_n,
  fpcd_in_if.sink                     in_chan,
  fpcd_out_if.source                  out_chan,
  input  logic                        cfg_we,
  input  logic [fpcd_pkg::SLOT_W-1:0] cfg_wdata
);
  import fpcd_pkg::*;

  ctl_t ctl;
  sts_t sts;

  fpcd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  fpcd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule

`default_nettype wire

/* tb/sv/fpcd_tb_if.sv */
`timescale 1ns / 100ps
// Interfaces used by the page cache directory testbench are the RTL ones (rtl/fpcd_if.sv).
// This file holds the directory scoreboard class; depends on fpcd_pkg.
`default_nettype none

package fpcd_tb_pkg;
  import fpcd_pkg::*;

  class dir_scoreboard;
    // directory model state
    logic [SLOT_W-1:0] rom_map [ROM_ENTRIES];
    logic [SLOT_W-1:0] nor_map [NOR_PAGES];
    bit                s_used  [MAX_SLOTS];
    bit                s_dirty [MAX_SLOTS];
    logic [1:0]        s_kind  [MAX_SLOTS];
    logic [PAGE_W-1:0] s_page  [MAX_SLOTS];
    int unsigned       victim;
    int unsigned       nor_cur;
    bit                nor_cur_ok;
    int unsigned       slots_cfg;
    res_t              pending[$];
    int                errors;

    function new();
      foreach (rom_map[i]) rom_map[i] = NOT_CACHED;
      foreach (nor_map[i]) nor_map[i] = NOT_CACHED;
      foreach (s_used[i]) begin
        s_used[i] = 0; s_dirty[i] = 0; s_kind[i] = 0; s_page[i] = 0;
      end
      victim = 0; nor_cur = 0; nor_cur_ok = 0; slots_cfg = MAX_SLOTS;
      errors = 0;
    endfunction

    function int unsigned live_slots();
      if (slots_cfg == 0) return 1;
      if (slots_cfg > MAX_SLOTS) return MAX_SLOTS;
      return slots_cfg;
    endfunction

    function void push(logic [1:0] st, bit h, int unsigned sl, bit f, bit wb,
                       int unsigned wp, int unsigned ws, bit l);
      res_t r;
      r.status = st; r.hit = h; r.slot = sl[8:0]; r.fill_needed = f;
      r.writeback = wb; r.writeback_page = wp[4:0]; r.writeback_slot = ws[8:0];
      r.last = l;
      pending.push_back(r);
    endfunction

    // lookup or claim of a slot
    function void load_page(bit is_nor, int unsigned idx, logic [1:0] kind,
                            int unsigned pg);
      int unsigned n, cur, v, wp, op;
      bit wb;
      n = live_slots();
      cur = is_nor ? nor_map[idx] : rom_map[idx];
      wb = 0; wp = 0;
      if (cur != NOT_CACHED && cur >= n) begin
        push(ST_STALE, 0, 0, 0, 0, 0, 0, 1); return;
      end
      if (cur != NOT_CACHED) begin
        if (is_nor) begin nor_cur = pg; nor_cur_ok = 1; end
        push(ST_DONE, 1, cur, 0, 0, 0, 0, 1); return;
      end
      if (victim >= n) victim = 0;
      v = victim;
      if (s_used[v]) begin
        op = s_page[v];
        if (s_kind[v] == KIND_NOR) begin
          if (s_dirty[v]) begin wb = 1; wp = op; end
          if (op < NOR_PAGES) nor_map[op] = NOT_CACHED;
        end else if (s_kind[v] < ROM_VOLUMES && op < ROM_PAGES) begin
          rom_map[s_kind[v] * ROM_PAGES + op] = NOT_CACHED;
        end
      end
      if (is_nor) nor_map[idx] = SLOT_W'(v); else rom_map[idx] = SLOT_W'(v);
      s_used[v] = 1; s_kind[v] = kind; s_page[v] = PAGE_W'(pg); s_dirty[v] = 0;
      victim = v + 1;
      if (victim >= n) victim = 0;
      if (is_nor) begin nor_cur = pg; nor_cur_ok = 1; end
      push(ST_DONE, 0, v, 1, wb, wp, wb ? v : 0, 1);
    endfunction

    function int unsigned nor_home(int unsigned p);
      int unsigned s;
      s = nor_map[p];
      if (s == NOT_CACHED || s >= MAX_SLOTS) return NOT_CACHED;
      if (!s_used[s] || s_kind[s] != KIND_NOR) return NOT_CACHED;
      return s;
    endfunction

    // note an accepted command beat
    function void note_cmd(logic [2:0] cmd, logic [1:0] vol, logic [6:0] pg);
      int unsigned s, k;
      case (cmd)
        CMD_LOAD_ROM: begin
          if (vol >= ROM_VOLUMES || pg >= ROM_PAGES) push(ST_RANGE, 0, 0, 0, 0, 0, 0, 1);
          else load_page(0, vol * ROM_PAGES + pg, vol, pg);
        end
        CMD_LOAD_NOR: begin
          if (pg >= NOR_PAGES) push(ST_RANGE, 0, 0, 0, 0, 0, 0, 1);
          else load_page(1, pg, KIND_NOR, pg);
        end
        CMD_MARK_DIRTY: begin
          if (!nor_cur_ok) push(ST_NO_MAP, 0, 0, 0, 0, 0, 0, 1);
          else begin
            s = nor_map[nor_cur];
            if (s == NOT_CACHED) push(ST_NO_MAP, 0, 0, 0, 0, 0, 0, 1);
            else if (s >= live_slots()) push(ST_STALE, 0, 0, 0, 0, 0, 0, 1);
            else begin
              s_dirty[s] = 1;
              push(ST_DONE, 0, s, 0, 0, 0, 0, 1);
            end
          end
        end
        CMD_WIPE_NOR: begin
          for (int p = 0; p < NOR_PAGES; p++) begin
            s = nor_home(p);
            if (s != NOT_CACHED) s_dirty[s] = 0;
          end
          push(ST_DONE, 0, 0, 0, 0, 0, 0, 1);
        end
        CMD_FLUSH: begin
          k = 0;
          for (int p = 0; p < NOR_PAGES; p++) begin
            s = nor_home(p);
            if (s != NOT_CACHED && s_dirty[s]) begin
              push(ST_DONE, 0, 0, 0, 1, p, s, 0);
              s_dirty[s] = 0;
              k++;
            end
          end
          if (k == 0) push(ST_DONE, 0, 0, 0, 0, 0, 0, 1);
          else pending[pending.size()-1].last = 1;
        end
        default: push(ST_RANGE, 0, 0, 0, 0, 0, 0, 1);
      endcase
    endfunction

    // check one result beat against the oldest expectation
    function void check_beat(res_t got);
      res_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass
endpackage

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Top of the page cache directory testbench: clock, reset, drivers, monitor.
// Depends on fpcd_pkg, rtl/fpcd_if.sv and fpcd_tb_pkg.
`default_nettype none

module tb_top;
  import fpcd_pkg::*;
  import fpcd_tb_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [SLOT_W-1:0] cfg_wdata = '0;
  bit   quiet_out = 0;

  fpcd_in_if  cmd_ch();
  fpcd_out_if res_ch();

  fifo_page_cache_directory dut (
    .clk(clk), .rst_n(rst_n), .in_chan(cmd_ch.sink), .out_chan(res_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  dir_scoreboard dir_sb;

  always #10 clk = ~clk;

  initial begin
    cmd_ch.valid = 0; cmd_ch.cmd = 0; cmd_ch.volume = 0; cmd_ch.page = 0;
    res_ch.ready = 0;
  end

  // send one command beat
  task automatic send_cmd(logic [2:0] c, logic [1:0] v, logic [6:0] p, bit gaps = 1);
    int unsigned w;
    w = gaps ? $urandom_range(0, 12) : 0;
    if ($urandom_range(0, 3) == 0) w = 0;
    repeat (w) @(posedge clk);
    cmd_ch.valid <= 1; cmd_ch.cmd <= c; cmd_ch.volume <= v; cmd_ch.page <= p;
    do @(posedge clk); while (!cmd_ch.ready);
    dir_sb.note_cmd(c, v, p);
    cmd_ch.valid <= 0;
    // block is busy decoding here, so the next beat is held back
    @(posedge clk);
  endtask

  task automatic drain();
    while (dir_sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_slots(int unsigned n);
    drain();
    cfg_we <= 1; cfg_wdata <= n[8:0];
    @(posedge clk);
    cfg_we <= 0;
    dir_sb.slots_cfg = n & 9'h1ff;
  endtask

  // random beat biased toward valid loads
  task automatic send_random(int unsigned pool);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) send_cmd(CMD_LOAD_ROM, 2'($urandom_range(0, 2)), 7'($urandom_range(0, pool)));
    else if (r < 65) send_cmd(CMD_LOAD_NOR, 2'd0, 7'($urandom_range(0, 31)));
    else if (r < 80) send_cmd(CMD_MARK_DIRTY, 2'($urandom), 7'($urandom));
    else if (r < 85) send_cmd(CMD_WIPE_NOR, 2'($urandom), 7'($urandom));
    else if (r < 92) send_cmd(CMD_FLUSH, 2'($urandom), 7'($urandom));
    else send_cmd(3'($urandom_range(0, 7)), 2'($urandom), 7'($urandom));
  endtask

  // result side: random stalls, check on accept
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        res_t got;
        got.status = res_ch.status; got.hit = res_ch.hit; got.slot = res_ch.slot;
        got.fill_needed = res_ch.fill_needed; got.writeback = res_ch.writeback;
        got.writeback_page = res_ch.writeback_page;
        got.writeback_slot = res_ch.writeback_slot; got.last = res_ch.last;
        dir_sb.check_beat(got);
      end
    end
  end

  initial begin
    int unsigned w;
    dir_sb = new();
    forever begin
      @(posedge clk);
      if (quiet_out) res_ch.ready <= 1;
      else begin
        w = $urandom_range(0, 12);
        if ($urandom_range(0, 2) == 0) w = 0;
        res_ch.ready <= (w == 0);
        repeat (w) @(posedge clk);
        if (w != 0) res_ch.ready <= 1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    // directed: errors and extremes
    send_cmd(CMD_MARK_DIRTY, 0, 0);
    send_cmd(CMD_FLUSH, 0, 0);
    send_cmd(CMD_LOAD_ROM, 2'd3, 7'd0);
    send_cmd(CMD_LOAD_ROM, 2'd2, 7'd127);
    send_cmd(CMD_LOAD_ROM, 2'd0, 7'd0);
    send_cmd(CMD_LOAD_ROM, 2'd0, 7'd0);
    send_cmd(CMD_LOAD_NOR, 2'd3, 7'd32);
    send_cmd(CMD_LOAD_NOR, 0, 7'd31);
    send_cmd(CMD_MARK_DIRTY, 0, 0);
    send_cmd(CMD_LOAD_NOR, 0, 7'd0);
    send_cmd(CMD_MARK_DIRTY, 0, 0);
    send_cmd(CMD_FLUSH, 0, 0);
    send_cmd(CMD_MARK_DIRTY, 0, 0);
    send_cmd(CMD_WIPE_NOR, 0, 0);
    send_cmd(CMD_FLUSH, 0, 0);
    send_cmd(3'd5, 0, 0);
    send_cmd(3'd7, 2'd3, 7'd127);
    // tiny cache: evictions with dirty writeback, stale entries later
    write_slots(2);
    send_cmd(CMD_LOAD_NOR, 0, 7'd5);
    send_cmd(CMD_MARK_DIRTY, 0, 0);
    send_cmd(CMD_LOAD_ROM, 1, 7'd9);
    send_cmd(CMD_LOAD_ROM, 1, 7'd10);
    send_cmd(CMD_MARK_DIRTY, 0, 0);
    write_slots(0);
    send_cmd(CMD_LOAD_ROM, 1, 7'd10);
    send_cmd(CMD_LOAD_ROM, 1, 7'd11);
    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      int unsigned n;
      case (ph)
        0: n = 416;
        1: n = 3;
        2: n = 511;
        3: n = $urandom_range(1, 40);
        4: n = 1;
        default: n = $urandom_range(0, 511);
      endcase
      write_slots(n);
      for (int i = 0; i < 65; i++) begin
        send_random(ph == 0 || ph == 2 ? 127 : 15);
        // one pause with everything drained
        if (ph == 3 && i == 30) while (dir_sb.pending.size() != 0) @(posedge clk);
      end
    end
    quiet_out = 1;
    for (int i = 0; i < 10; i++) send_random(127);
    drain();
    if (dir_sb.errors == 0) $display("[fifo_page_cache_directory] OK");
    else $display("[fifo_page_cache_directory] ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("[fifo_page_cache_directory] ERROR");
    $finish;
  end
endmodule

`default_nettype wire
